// ===== rtl/cnf_literal_simplifier_assert.svh =====
// Assertion macros for the CNF literal simplifier.
// Include this header in any module that carries concurrent checks.
`ifndef CNF_LITERAL_SIMPLIFIER_ASSERT_SVH
`define CNF_LITERAL_SIMPLIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CNF_ASSERT(lbl, prp) \
   lbl: assert property (@(posedge clock) disable iff (reset) prp) \
      else $error("assertion failed");
`define CNF_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");
`else
`define CNF_ASSERT(lbl, prp)
`define CNF_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/cnf_ls_pkg.sv =====
// Shared constants, codes and state type of the CNF literal simplifier.
// No dependencies.
package cnf_ls_pkg;
   localparam int MAX_CLAUSES  = 256;
   localparam int MAX_LITERALS = 8;
   localparam int LIT_W        = 11;
   localparam int SLOT_W       = $clog2(MAX_CLAUSES);
   localparam int POS_W        = $clog2(MAX_LITERALS);
   localparam int CNT_W        = $clog2(MAX_CLAUSES + 1);
   localparam int LEN_W        = $clog2(MAX_LITERALS + 1);
   localparam int ADDR_W       = SLOT_W + POS_W;
   localparam int LIT_DEPTH    = MAX_CLAUSES * MAX_LITERALS;

   localparam logic [1:0] KIND_APPEND   = 2'd0;
   localparam logic [1:0] KIND_SIMPLIFY = 2'd1;
   localparam logic [1:0] KIND_CLEAR    = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLAUSE,
      S_LEN,
      S_LIT,
      S_CHK,
      S_REPL,
      S_MVLEN,
      S_MV,
      S_MVW,
      S_DONE
   } state_type;
endpackage

// ===== rtl/cnf_ls_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cnf_ls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/cnf_literal_simplifier.sv =====
// Append, clear and unused kinds: S_IDLE takes the request, S_DONE registers the response
// beat, and S_IDLE takes the next one. Simplify: per clause, S_CLAUSE and S_LEN read its
// length, S_LIT and S_CHK check each literal; a negated key literal is dropped (S_REPL
// moves the last literal into its place), a satisfied clause is overwritten by the last
// clause (S_MVLEN, S_MV, S_MVW), and the open clause then moves behind the shrunken store.
// A waiting response holds the sequencer; reset clears counts, memories keep contents.
module cnf_literal_simplifier
   import cnf_ls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [10:0] literal, [15:11] zero
   input  logic        req_tlast,  // end_of_clause
   input  logic [1:0]  req_tuser,  // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [8:0] clause_count, [15:9] zero
   output logic        rsp_tuser   // [0] status
);
`include "cnf_literal_simplifier_assert.svh"

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  total_ff, total_in, old_ff, old_in, i_ff, i_in;
   logic [LEN_W-1:0]  open_ff, open_in, j_ff, j_in, len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic [SLOT_W-1:0] src_ff, src_in, dst_ff, dst_in;
   logic              open_mv_ff, open_mv_in, status_ff, status_in;
   logic [LIT_W-1:0]  key_ff, key_in, neg_key;
   logic              rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              lit_we, len_we;
   logic [ADDR_W-1:0] lit_waddr, lit_raddr;
   logic [LIT_W-1:0]  lit_wdata, lit_rdata;
   logic [SLOT_W-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0]  len_wdata, len_rdata;
   logic              accept, out_free;
   logic [CNT_W-1:0]  last;
   logic [LEN_W-1:0]  len_m1;

   cnf_ls_ram #(.WIDTH(LIT_W), .DEPTH(LIT_DEPTH)) u_lit_ram (
      .clock(clock), .wr_en(lit_we), .wr_addr(lit_waddr), .wr_data(lit_wdata),
      .rd_addr(lit_raddr), .rd_data(lit_rdata)
   );

   cnf_ls_ram #(.WIDTH(LEN_W), .DEPTH(MAX_CLAUSES)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_addr(len_raddr), .rd_data(len_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign neg_key    = LIT_W'(-key_ff);
   assign last       = total_ff - CNT_W'(1);
   assign len_m1     = len_ff - LEN_W'(1);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(16 - CNT_W){1'b0}}, rsp_count_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == KIND_SIMPLIFY) ? S_CLAUSE : S_DONE;
            end
         end
         S_CLAUSE: begin
            if (i_ff < total_ff) begin
               state_in = S_LEN;
            end else if (open_ff != '0 && total_ff != old_ff) begin
               state_in = S_MV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LEN: state_in = S_LIT;
         S_LIT: state_in = (j_ff < len_ff) ? S_CHK : S_CLAUSE;
         S_CHK: begin
            if (lit_rdata == key_ff) begin
               state_in = (i_ff < last) ? S_MVLEN : S_CLAUSE;
            end else if (lit_rdata == neg_key && j_ff < len_m1) begin
               state_in = S_REPL;
            end else begin
               state_in = S_LIT;
            end
         end
         S_REPL:  state_in = S_LIT;
         S_MVLEN: state_in = S_MV;
         S_MV: begin
            if (k_ff < cnt_ff) begin
               state_in = S_MVW;
            end else begin
               state_in = open_mv_ff ? S_DONE : S_CLAUSE;
            end
         end
         S_MVW:   state_in = S_MV;
         S_DONE:  state_in = out_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      total_in = total_ff;  old_in = old_ff;  i_in = i_ff;
      open_in = open_ff;  j_in = j_ff;  len_in = len_ff;
      cnt_in = cnt_ff;  k_in = k_ff;  src_in = src_ff;  dst_in = dst_ff;
      open_mv_in = open_mv_ff;  status_in = status_ff;  key_in = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;  rsp_count_in = rsp_count_ff;
      lit_we = 1'b0;  lit_waddr = {i_ff[SLOT_W-1:0], j_ff[POS_W-1:0]};
      lit_wdata = lit_rdata;
      lit_raddr = {i_ff[SLOT_W-1:0], j_ff[POS_W-1:0]};
      len_we = 1'b0;  len_waddr = i_ff[SLOT_W-1:0];  len_wdata = len_ff;
      len_raddr = i_ff[SLOT_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = req_tdata[LIT_W-1:0];
               status_in = 1'b0;
               case (req_tuser)
                  KIND_APPEND: begin
                     if (total_ff >= CNT_W'(MAX_CLAUSES)) begin
                        status_in = 1'b1;
                     end else begin
                        if (open_ff >= LEN_W'(MAX_LITERALS)) begin
                           status_in = 1'b1;
                           len_wdata = open_ff;
                        end else begin
                           lit_we = 1'b1;
                           lit_waddr = {total_ff[SLOT_W-1:0], open_ff[POS_W-1:0]};
                           lit_wdata = req_tdata[LIT_W-1:0];
                           open_in = open_ff + LEN_W'(1);
                           len_wdata = open_ff + LEN_W'(1);
                        end
                        if (req_tlast) begin
                           len_we = 1'b1;
                           len_waddr = total_ff[SLOT_W-1:0];
                           total_in = total_ff + CNT_W'(1);
                           open_in = '0;
                        end
                     end
                  end
                  KIND_SIMPLIFY: begin
                     i_in = '0;
                     old_in = total_ff;
                     open_mv_in = 1'b0;
                  end
                  KIND_CLEAR: begin
                     total_in = '0;
                     open_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLAUSE: begin
            // Once every clause is done, the open clause follows the shrunken store.
            if (i_ff >= total_ff) begin
               src_in = old_ff[SLOT_W-1:0];
               dst_in = total_ff[SLOT_W-1:0];
               cnt_in = open_ff;
               k_in = '0;
               open_mv_in = 1'b1;
            end
         end
         S_LEN: begin
            len_in = len_rdata;
            j_in = '0;
         end
         S_LIT: begin
            if (j_ff >= len_ff) begin
               len_we = 1'b1;
               i_in = i_ff + CNT_W'(1);
            end
         end
         S_CHK: begin
            if (lit_rdata == key_ff) begin
               if (i_ff < last) begin
                  len_raddr = last[SLOT_W-1:0];
                  src_in = last[SLOT_W-1:0];
                  dst_in = i_ff[SLOT_W-1:0];
                  k_in = '0;
               end else begin
                  total_in = last;
               end
            end else if (lit_rdata == neg_key) begin
               if (j_ff < len_m1) begin
                  lit_raddr = {i_ff[SLOT_W-1:0], len_m1[POS_W-1:0]};
               end else begin
                  len_in = len_m1;
               end
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
         end
         S_REPL: begin
            lit_we = 1'b1;
            len_in = len_m1;
         end
         S_MVLEN: begin
            cnt_in = len_rdata;
            len_we = 1'b1;
            len_waddr = dst_ff;
            len_wdata = len_rdata;
         end
         S_MV: begin
            lit_raddr = {src_ff, k_ff[POS_W-1:0]};
            if (k_ff >= cnt_ff && !open_mv_ff) begin
               total_in = last;
            end
         end
         S_MVW: begin
            lit_we = 1'b1;
            lit_waddr = {dst_ff, k_ff[POS_W-1:0]};
            k_in = k_ff + LEN_W'(1);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         open_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         open_ff <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;  i_ff <= i_in;  j_ff <= j_in;  len_ff <= len_in;
      cnt_ff <= cnt_in;  k_ff <= k_in;  src_ff <= src_in;  dst_ff <= dst_in;
      open_mv_ff <= open_mv_in;  status_ff <= status_in;  key_ff <= key_in;
      rsp_status_ff <= rsp_status_in;  rsp_count_ff <= rsp_count_in;
   end

   `CNF_ASSERT(a_total_bound, total_ff <= CNT_W'(MAX_CLAUSES))
   `CNF_ASSERT(a_open_bound, open_ff <= LEN_W'(MAX_LITERALS))
   `CNF_ASSERT(a_scan_bound, (state_ff == S_LIT || state_ff == S_CHK) |-> i_ff < total_ff)
   `CNF_ASSERT_NEVER(a_lit_past_len, state_ff == S_CHK && j_ff >= len_ff)
endmodule
